@@ rtl/core/llt_pkg.sv @@
// shared constants and types for the longest increasing subsequence block
`timescale 1ns / 1ps
package llt_pkg;

   localparam int MAX_LEN     = 1024;
   localparam int IDX_W       = $clog2(MAX_LEN);
   localparam int LEN_W       = $clog2(MAX_LEN + 1);
   localparam int VALUE_W     = 32;
   localparam int LIS_W       = 11;
   localparam int RSP_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      start_req;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } back_state_type;

endpackage

@@ rtl/core/lis_length_tail_table_top.sv @@
// top level of the longest strictly increasing subsequence length block
//
// req channel: one beat per sequence element; tdata carries the signed value,
// tuser carries the start flag that opens a new sequence with this element.
// rsp channel: exactly one beat per request beat, in order; tdata carries the
// current subsequence length, tuser flags an append dropped on a full table.
// requests enter a two-entry queue, so the sender is held off only when the
// queue is full. the search engine keeps a 1024-entry table of smallest tails
// in a ram and binary-searches its filled part, one ram probe per cycle.
// an item passes through the engine in an accept step, the search probes and a
// final write step; a start beat or an empty table skips the search probes.
// the result sits in an output register; a stalled receiver holds the engine
// in its final step while the queue still takes new beats.
// reset clears the length, the queue and the output valid; the table contents
// need no clearing, as only entries below the length are ever read.
`timescale 1ns / 1ps
module lis_length_tail_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] value
   input  logic [0:0]  req_tuser,  // [0] start_req
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [10:0] lis_length, [15:11] zero
   output logic [0:0]  rsp_tuser   // [0] overflow
);
   import llt_pkg::*;

   logic             q_valid;
   logic             q_ready;
   item_type         q_item;
   logic [LIS_W-1:0] rsp_length;
   logic             rsp_overflow;

   llt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_value  (req_tdata[VALUE_W-1:0]),
      .in_start  (req_tuser[0]),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   llt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (q_valid),
      .item_ready   (q_ready),
      .item         (q_item),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_length   (rsp_length),
      .rsp_overflow (rsp_overflow)
   );

   assign rsp_tdata = {{(RSP_DATA_W - LIS_W){1'b0}}, rsp_length};
   assign rsp_tuser = rsp_overflow;

endmodule

@@ rtl/core/llt_ram.sv @@
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
module llt_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/llt_front.sv @@
// input side: takes beats and parks them in a short queue for the search engine
`timescale 1ns / 1ps
module llt_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [llt_pkg::VALUE_W-1:0]   in_value,
   input  logic                          in_start,
   output logic                          out_valid,
   input  logic                          out_ready,
   output llt_pkg::item_type             out_item
);
   import llt_pkg::*;

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   logic              pop;

   assign in_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff].value     <= in_value;
         slot_ff[wr_ptr_ff].start_req <= in_start;
      end
   end

endmodule

@@ rtl/core/llt_back.sv @@
// search engine: binary search over the tail table, update, and result register
`timescale 1ns / 1ps
module llt_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_valid,
   output logic                         item_ready,
   input  llt_pkg::item_type            item,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [llt_pkg::LIS_W-1:0]    rsp_length,
   output logic                         rsp_overflow
);
   import llt_pkg::*;

   back_state_type            state_ff, state_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [LEN_W-1:0]          len_ff, len_in;
   logic [LEN_W-1:0]          lo_ff, lo_in;
   logic [LEN_W-1:0]          hi_ff, hi_in;
   logic [LEN_W-1:0]          mid_ff, mid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [LIS_W-1:0]          rsp_len_ff, rsp_len_in;
   logic                      rsp_ovf_ff, rsp_ovf_in;

   logic                      rd_en;
   logic [VALUE_W-1:0]        rd_data;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;

   llt_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_LEN)
   ) u_tail_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_en   (rd_en),
      .rd_addr (mid_in[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      logic [LEN_W-1:0] len_eff;
      logic [LEN_W-1:0] lo_n;
      logic [LEN_W-1:0] hi_n;
      logic [LEN_W:0]   mid_sum;

      state_in     = state_ff;
      value_in     = value_ff;
      len_in       = len_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      item_ready   = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = lo_ff[IDX_W-1:0];
      len_eff      = '0;
      lo_n         = lo_ff;
      hi_n         = hi_ff;
      mid_sum      = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               // start flag drops the old sequence before this value
               len_eff  = item.start_req ? '0 : len_ff;
               value_in = item.value;
               len_in   = len_eff;
               lo_in    = '0;
               hi_in    = len_eff;
               if (len_eff != '0) begin
                  mid_in   = len_eff >> 1;
                  rd_en    = 1'b1;
                  state_in = ST_SEARCH;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SEARCH: begin
            // tail at mid is ready; narrow and fetch the next probe in the same cycle
            if ($signed(rd_data) < value_ff) begin
               lo_n = mid_ff + 1'b1;
               hi_n = hi_ff;
            end else begin
               lo_n = lo_ff;
               hi_n = mid_ff;
            end
            lo_in = lo_n;
            hi_in = hi_n;
            if (lo_n < hi_n) begin
               mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
               mid_in  = mid_sum[LEN_W:1];
               rd_en   = 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ovf_in   = 1'b0;
               state_in     = ST_IDLE;
               if (lo_ff == len_ff) begin
                  if (len_ff < LEN_W'(MAX_LEN)) begin
                     wr_en      = 1'b1;
                     wr_addr    = len_ff[IDX_W-1:0];
                     len_in     = len_ff + 1'b1;
                     rsp_len_in = LIS_W'(len_ff + 1'b1);
                  end else begin
                     // table full: append dropped, length saturates
                     rsp_ovf_in = 1'b1;
                     rsp_len_in = LIS_W'(len_ff);
                  end
               end else begin
                  wr_en      = 1'b1;
                  wr_addr    = lo_ff[IDX_W-1:0];
                  rsp_len_in = LIS_W'(len_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      rsp_len_ff <= rsp_len_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_length   = rsp_len_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

@@ test/lis_length_tail_table_top_tb.sv @@
// testbench for the longest strictly increasing subsequence length block
`timescale 1ns / 1ps

typedef struct packed {
   logic [llt_pkg::LIS_W-1:0] length;
   logic                      overflow;
} length_beat_type;

class length_tracker;
   logic signed [llt_pkg::VALUE_W-1:0] smallest_tails [llt_pkg::MAX_LEN];
   int              tail_count = 0;
   length_beat_type pending_lengths [$];
   int              errors = 0;

   // patience step: find first tail not less than the value, replace it or append
   function void advance_tails(input logic signed [llt_pkg::VALUE_W-1:0] value,
                               input logic begin_run);
      int              lo;
      int              hi;
      int              mid;
      length_beat_type beat;
      if (begin_run)
         tail_count = 0;
      lo = 0;
      hi = tail_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (smallest_tails[mid] < value)
            lo = mid + 1;
         else
            hi = mid;
      end
      beat.overflow = 1'b0;
      if (lo == tail_count) begin
         if (tail_count < llt_pkg::MAX_LEN) begin
            smallest_tails[tail_count] = value;
            tail_count++;
         end else begin
            beat.overflow = 1'b1;
         end
      end else begin
         smallest_tails[lo] = value;
      end
      beat.length = tail_count[llt_pkg::LIS_W-1:0];
      pending_lengths.push_back(beat);
   endfunction

   function void check_length(input logic [llt_pkg::RSP_DATA_W-1:0] data,
                              input logic [0:0] user);
      length_beat_type                want;
      logic [llt_pkg::RSP_DATA_W-1:0] want_data;
      if (pending_lengths.size() == 0) begin
         $display("%0t: rsp beat with nothing outstanding, tdata %h tuser %b",
                  $time, data, user);
         errors++;
         return;
      end
      want = pending_lengths.pop_front();
      want_data = {{(llt_pkg::RSP_DATA_W - llt_pkg::LIS_W){1'b0}}, want.length};
      if (data !== want_data) begin
         $display("%0t: length mismatch, expected %h, actual %h", $time, want_data, data);
         errors++;
      end
      if (user[0] !== want.overflow) begin
         $display("%0t: overflow mismatch, expected %b, actual %b",
                  $time, want.overflow, user[0]);
         errors++;
      end
   endfunction
endclass

module lis_length_tail_table_top_tb;
   import llt_pkg::*;

   localparam int     CYCLE_LIMIT = 500000;
   localparam int     SETTLE_CYCLES = 30;
   localparam int     FULL_CLIMB = MAX_LEN + 11;
   localparam longint VALUE_MAX = 64'sd2147483647;
   localparam longint VALUE_MIN = -64'sd2147483648;

   typedef enum {PICK_TREND, PICK_ANY, PICK_NARROW} pick_kind_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [VALUE_W-1:0]    req_tdata;   // [31:0] value
   logic [0:0]            req_tuser;   // [0] start_req
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [10:0] lis_length, [15:11] zero
   logic [0:0]            rsp_tuser;   // [0] overflow

   length_tracker lis_board = new;
   int            sender_idle_pct;
   int            receiver_idle_pct;
   int            hold_left;
   int            items_sent;
   int            cycles;

   lis_length_tail_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[lis_length_tail_table_top] ERROR");
         $finish;
      end
   end

   // accepted beats on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            lis_board.advance_tails(req_tdata, req_tuser[0]);
         if (rsp_tvalid && rsp_tready)
            lis_board.check_length(rsp_tdata, rsp_tuser);
      end
   end

   // receiver: random back-pressure, or a long hold-off when requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   task automatic send_item(input logic [VALUE_W-1:0] value, input logic begin_run);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= begin_run;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   function automatic logic signed [VALUE_W-1:0] next_value(input pick_kind_type kind,
                                                           input logic signed [VALUE_W-1:0] last);
      longint cand;
      case (kind)
         PICK_TREND:  cand = longint'(last) + longint'($urandom_range(2000)) - 500;
         PICK_NARROW: cand = longint'($urandom_range(16)) - 8;
         default:     cand = longint'($signed($urandom));
      endcase
      if (cand > VALUE_MAX)
         cand = VALUE_MAX;
      if (cand < VALUE_MIN)
         cand = VALUE_MIN;
      return cand[VALUE_W-1:0];
   endfunction

   // one sequence; a few skip the opening start flag or restart midway
   task automatic send_run(input int run_len);
      pick_kind_type             kind;
      logic signed [VALUE_W-1:0] last_value;
      logic                      begin_run;
      int                        r;
      r = $urandom_range(99);
      kind = (r < 70) ? PICK_TREND : ((r < 85) ? PICK_ANY : PICK_NARROW);
      last_value = $urandom;
      for (int k = 0; k < run_len; k++) begin
         if (k == 0)
            begin_run = ($urandom_range(99) >= 10);
         else
            begin_run = ($urandom_range(99) < 3);
         if ($urandom_range(99) < 5)
            last_value = next_value(PICK_ANY, last_value);
         else
            last_value = next_value(kind, last_value);
         send_item(last_value, begin_run);
      end
   endtask

   task automatic send_runs(input int goal);
      while (items_sent < goal)
         send_run($urandom_range(1, 60));
   endtask

   // strictly increasing run past the table size, with one equal value once full
   task automatic send_full_climb();
      longint first;
      longint climb;
      first = VALUE_MIN + longint'($urandom_range(1000));
      climb = first;
      send_item(first[VALUE_W-1:0], 1'b1);
      for (int k = 1; k < FULL_CLIMB; k++) begin
         if (k == MAX_LEN + 5) begin
            send_item(first[VALUE_W-1:0], 1'b0);
         end else begin
            climb = climb + longint'($urandom_range(1, 1 << 20));
            send_item(climb[VALUE_W-1:0], 1'b0);
         end
      end
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (lis_board.pending_lengths.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      hold_left = 0;
      items_sent = 0;
      cycles = 0;
      sender_idle_pct = 6;
      receiver_idle_pct = 54;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes, equal values, replace and append, restarts
      send_item(32'h0000_0000, 1'b1);
      send_item(32'h7FFF_FFFF, 1'b0);
      send_item(32'h8000_0000, 1'b0);
      send_item(32'h8000_0000, 1'b0);
      send_item(32'h7FFF_FFFF, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b0);
      send_item(32'h0000_0005, 1'b0);
      send_item(32'h5555_5555, 1'b0);
      send_item(32'hAAAA_AAAA, 1'b0);
      send_item(32'h7FFF_FFFF, 1'b1);
      send_item(32'h7FFF_FFFF, 1'b0);
      send_item(32'h8000_0000, 1'b1);
      send_item(32'h8000_0001, 1'b0);
      send_item(32'd40, 1'b1);
      send_item(32'd30, 1'b0);
      send_item(32'd20, 1'b0);
      send_item(32'd10, 1'b0);
      send_item(32'd10, 1'b0);
      send_item(32'd11, 1'b0);

      send_runs(items_sent + 300);
      wait_for_results();

      sender_idle_pct = 54;
      receiver_idle_pct = 6;
      // receiver stalls long enough for the queue to fill and hold off req
      hold_left = 300;
      send_run(12);
      send_runs(items_sent + 300);
      wait_for_results();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      send_full_climb();
      send_runs(items_sent + 150);
      wait_for_results();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (lis_board.errors == 0 && lis_board.pending_lengths.size() == 0)
         $display("[lis_length_tail_table_top] OK");
      else
         $display("[lis_length_tail_table_top] ERROR");
      $finish;
   end

endmodule

@@ lis_length_tail_table_top.f @@
rtl/core/llt_pkg.sv
rtl/core/llt_ram.sv
rtl/core/llt_front.sv
rtl/core/llt_back.sv
rtl/core/lis_length_tail_table_top.sv
test/lis_length_tail_table_top_tb.sv
